// ===== src/discrete_state_space_system_macros.svh =====
// Assertion macros for the discrete state-space system checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DISCRETE_STATE_SPACE_SYSTEM_MACROS_SVH
`define DISCRETE_STATE_SPACE_SYSTEM_MACROS_SVH

// Same-cycle implication or plain property.
`define DSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dss_pkg.sv =====
// Shared constants, command and status types of the discrete state-space system.
// Used by the controller, the datapath, the top level and the checker.
package dss_pkg;

  localparam int MAX_STATES_DEF  = 4;
  localparam int MAX_INPUTS_DEF  = 2;
  localparam int MAX_OUTPUTS_DEF = 2;

  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int STATES_W   = 3;
  localparam int INPUTS_W   = 2;
  localparam int OUTPUTS_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int S_TDATA_W  = 104;
  localparam int M_TDATA_W  = 64;

  localparam logic [STATES_W-1:0]  STATES_RST  = 3'd4;
  localparam logic [INPUTS_W-1:0]  INPUTS_RST  = 2'd2;
  localparam logic [OUTPUTS_W-1:0] OUTPUTS_RST = 2'd2;

  // Opcodes of an input item.
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_OUTPUT = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STATES_USED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUTS_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_USED = 2'd2;

  // Index width for an array of n entries, at least one bit.
  function automatic int idx_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the fields of the accepted item
    logic mem_we;       // write the captured coefficient
    logic clear_y;      // zero the output accumulators
    logic shadow_load;  // copy the state into the next-state shadow
    logic term_vld;     // one product term is issued
    logic term_first;   // first term of a row
    logic term_last;    // last term of a row
    logic term_dest_y;  // row result goes to y, else to the shadow state
    logic term_is_u;    // operand is an input signal, else a state
    logic commit;       // shadow state becomes the state
    logic publish;      // move y into the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
  } sts_t;

endpackage

// ===== src/dss_ctrl.sv =====
// Controller of the discrete state-space system: configuration registers,
// the item state machine and the term sequencer. Depends on dss_pkg.
module dss_ctrl #(
  parameter int MAX_STATES  = dss_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUTS  = dss_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dss_pkg::MAX_OUTPUTS_DEF,
  parameter int AW          = 6,
  parameter int RIW         = 1,
  parameter int OIW         = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [dss_pkg::OP_W-1:0]       opcode_i,
  input  logic                           cfg_we_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output dss_pkg::cmd_t                  cmd_o,
  input  dss_pkg::sts_t                  sts_i,
  output logic [AW-1:0]                  term_addr_o,
  output logic [RIW-1:0]                 term_row_o,
  output logic [OIW-1:0]                 term_opnd_o
);

  localparam int MAXV = (MAX_STATES + MAX_INPUTS > MAX_OUTPUTS) ?
                        (MAX_STATES + MAX_INPUTS) : MAX_OUTPUTS;
  localparam int KW   = $clog2(MAXV + 1);
  localparam int CW   = (KW > 3) ? KW : 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [dss_pkg::STATES_W-1:0]  states_q;
  logic [dss_pkg::INPUTS_W-1:0]  inputs_q;
  logic [dss_pkg::OUTPUTS_W-1:0] outputs_q;

  logic [dss_pkg::OP_W-1:0] op_q, op_d;
  logic [CW-1:0] ns_q, ns_d, nrows_q, nrows_d, nterms_q, nterms_d;
  logic [CW-1:0] row_q, row_d, k_q, k_d;
  logic [AW-1:0] addr_q, addr_d, row_base_q, row_base_d, stride_q, stride_d;
  logic          drain_q, drain_d;

  logic [CW-1:0] ns_c, ni_c, no_c;
  logic [AW-1:0] lc_c;
  logic          accept;
  logic          is_u;
  logic          last_term, last_row;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      states_q  <= dss_pkg::STATES_RST;
      inputs_q  <= dss_pkg::INPUTS_RST;
      outputs_q <= dss_pkg::OUTPUTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dss_pkg::CFG_STATES_USED:  states_q  <= cfg_data_i;
        dss_pkg::CFG_INPUTS_USED:  inputs_q  <= cfg_data_i[dss_pkg::INPUTS_W-1:0];
        dss_pkg::CFG_OUTPUTS_USED: outputs_q <= cfg_data_i[dss_pkg::OUTPUTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts clamped to the sizes the hardware was built for.
  always_comb begin
    ns_c = (CW'(states_q) > CW'(MAX_STATES)) ? CW'(MAX_STATES) : CW'(states_q);
    ni_c = (CW'(inputs_q) > CW'(MAX_INPUTS)) ? CW'(MAX_INPUTS) : CW'(inputs_q);
    no_c = (CW'(outputs_q) > CW'(MAX_OUTPUTS)) ? CW'(MAX_OUTPUTS) : CW'(outputs_q);
    lc_c = AW'(ns_c) * AW'(ns_c + ni_c);
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign is_u       = (k_q >= ns_q);
  assign last_term  = (k_q == nterms_q - CW'(1));
  assign last_row   = (row_q == nrows_q - CW'(1));

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ns_d       = ns_q;
    nrows_d    = nrows_q;
    nterms_d   = nterms_q;
    row_d      = row_q;
    k_d        = k_q;
    addr_d     = addr_q;
    row_base_d = row_base_q;
    stride_d   = stride_q;
    drain_d    = drain_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = opcode_i;
          case (opcode_i)
            dss_pkg::OP_LOAD:   state_d = ST_LOAD;
            dss_pkg::OP_OUTPUT: state_d = ST_SETUP;
            dss_pkg::OP_UPDATE: state_d = ST_SETUP;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        state_d = ST_IDLE;
      end
      ST_SETUP: begin
        // A row's terms lie one stride apart in the store: the input columns
        // follow the state columns with the same stride.
        ns_d     = ns_c;
        nterms_d = ns_c + ni_c;
        row_d    = '0;
        k_d      = '0;
        drain_d  = 1'b0;
        if (op_q == dss_pkg::OP_UPDATE) begin
          nrows_d    = ns_c;
          stride_d   = AW'(ns_c);
          row_base_d = '0;
          addr_d     = '0;
        end else begin
          nrows_d    = no_c;
          stride_d   = AW'(no_c);
          row_base_d = lc_c;
          addr_d     = lc_c;
        end
        if ((nrows_d == '0) || (nterms_d == '0)) begin
          state_d = ST_DRAIN;
        end else begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_term) begin
          if (last_row) begin
            state_d = ST_DRAIN;
          end else begin
            row_d      = row_q + CW'(1);
            k_d        = '0;
            row_base_d = row_base_q + AW'(1);
            addr_d     = row_base_q + AW'(1);
          end
        end else begin
          k_d    = k_q + CW'(1);
          addr_d = addr_q + stride_q;
        end
      end
      ST_DRAIN: begin
        // Draining lets the last product pass the s1 and s2 pipeline registers and reach its destination.
        drain_d = ~drain_q;
        if (drain_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (op_q == dss_pkg::OP_UPDATE) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= dss_pkg::OP_LOAD;
      ns_q       <= '0;
      nrows_q    <= '0;
      nterms_q   <= '0;
      row_q      <= '0;
      k_q        <= '0;
      addr_q     <= '0;
      row_base_q <= '0;
      stride_q   <= '0;
      drain_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      ns_q       <= ns_d;
      nrows_q    <= nrows_d;
      nterms_q   <= nterms_d;
      row_q      <= row_d;
      k_q        <= k_d;
      addr_q     <= addr_d;
      row_base_q <= row_base_d;
      stride_q   <= stride_d;
      drain_q    <= drain_d;
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.capture     = accept;
    cmd_o.mem_we      = (state_q == ST_LOAD);
    cmd_o.clear_y     = accept && (opcode_i == dss_pkg::OP_OUTPUT);
    cmd_o.shadow_load = accept && (opcode_i == dss_pkg::OP_UPDATE);
    cmd_o.term_vld    = (state_q == ST_ISSUE);
    cmd_o.term_first  = (k_q == '0);
    cmd_o.term_last   = last_term;
    cmd_o.term_dest_y = (op_q == dss_pkg::OP_OUTPUT);
    cmd_o.term_is_u   = is_u;
    cmd_o.commit      = (state_q == ST_FINISH) && (op_q == dss_pkg::OP_UPDATE);
    cmd_o.publish     = (state_q == ST_FINISH) && (op_q == dss_pkg::OP_OUTPUT) &&
                        sts_i.out_free;
  end

  assign term_addr_o = addr_q;
  assign term_row_o  = RIW'(row_q);
  assign term_opnd_o = is_u ? OIW'(k_q - ns_q) : OIW'(k_q);

endmodule

// ===== src/dss_dp.sv =====
// Datapath of the discrete state-space system: coefficient memory, state,
// shared multiply-accumulate pipeline and output register. Depends on dss_pkg.
module dss_dp #(
  parameter int MAX_STATES  = dss_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUTS  = dss_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dss_pkg::MAX_OUTPUTS_DEF,
  parameter int COEF_DEPTH  = 36,
  parameter int AW          = 6,
  parameter int RIW         = 1,
  parameter int OIW         = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dss_pkg::cmd_t                      cmd_i,
  output dss_pkg::sts_t                      sts_o,
  input  logic [AW-1:0]                      term_addr_i,
  input  logic [RIW-1:0]                     term_row_i,
  input  logic [OIW-1:0]                     term_opnd_i,
  input  logic [dss_pkg::IDX_W-1:0]          coef_index_i,
  input  logic signed [dss_pkg::DATA_W-1:0]  coef_value_i,
  input  logic signed [dss_pkg::DATA_W-1:0]  u_first_i,
  input  logic signed [dss_pkg::DATA_W-1:0]  u_second_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic signed [dss_pkg::DATA_W-1:0]  y_first_o,
  output logic signed [dss_pkg::DATA_W-1:0]  y_second_o
);

  localparam int DW    = dss_pkg::DATA_W;
  localparam int PW    = 2 * DW;
  localparam int RW    = PW - 16;
  localparam int ACC_W = RW + 1 + $clog2(MAX_STATES + MAX_INPUTS);

  function automatic logic [DW-1:0] sat32(logic [ACC_W-1:0] v);
    logic [ACC_W-DW:0] upper;
    upper = v[ACC_W-1:DW-1];
    if ((&upper) || !(|upper)) begin
      return v[DW-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  logic [DW-1:0] mem_q [COEF_DEPTH];

  logic [dss_pkg::IDX_W-1:0] idx_q;
  logic [DW-1:0]             val_q;
  logic signed [DW-1:0]      u_q  [MAX_INPUTS];
  logic signed [DW-1:0]      x_q  [MAX_STATES];
  logic signed [DW-1:0]      xs_q [MAX_STATES];
  logic signed [DW-1:0]      y_q  [MAX_OUTPUTS];

  logic                 s1_vld_q, s1_first_q, s1_last_q, s1_dest_y_q;
  logic [RIW-1:0]       s1_row_q;
  logic signed [DW-1:0] s1_coef_q, s1_opnd_q;
  logic                 s2_vld_q, s2_first_q, s2_last_q, s2_dest_y_q;
  logic [RIW-1:0]       s2_row_q;
  logic signed [PW-1:0] s2_prod_q;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [DW-1:0]        row_sat;
  logic                 row_wr;

  logic signed [DW-1:0] opnd_val;
  logic signed [DW-1:0] y1_sel;
  logic                 mem_wr;
  logic                 m_tvalid_q;
  logic signed [DW-1:0] y0_out_q, y1_out_q;

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= coef_index_i;
      val_q <= coef_value_i;
      for (int i = 0; i < MAX_INPUTS; i++) begin
        if (i == 0) begin
          u_q[i] <= u_first_i;
        end else if (i == 1) begin
          u_q[i] <= u_second_i;
        end else begin
          u_q[i] <= '0;
        end
      end
    end
  end

  // Coefficient memory: one write port, one registered read port.
  assign mem_wr = cmd_i.mem_we && (32'(idx_q) < 32'(COEF_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[AW'(idx_q)] <= val_q;
    end
    if (cmd_i.term_vld) begin
      s1_coef_q <= mem_q[term_addr_i];
    end
  end

  always_comb begin
    opnd_val = '0;
    for (int i = 0; i < MAX_STATES; i++) begin
      if (!cmd_i.term_is_u && (OIW'(i) == term_opnd_i)) begin
        opnd_val = x_q[i];
      end
    end
    for (int i = 0; i < MAX_INPUTS; i++) begin
      if (cmd_i.term_is_u && (OIW'(i) == term_opnd_i)) begin
        opnd_val = u_q[i];
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.term_vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.term_vld) begin
      s1_first_q  <= cmd_i.term_first;
      s1_last_q   <= cmd_i.term_last;
      s1_dest_y_q <= cmd_i.term_dest_y;
      s1_row_q    <= term_row_i;
      s1_opnd_q   <= opnd_val;
    end
    if (s1_vld_q) begin
      s2_first_q  <= s1_first_q;
      s2_last_q   <= s1_last_q;
      s2_dest_y_q <= s1_dest_y_q;
      s2_row_q    <= s1_row_q;
      s2_prod_q   <= s1_coef_q * s1_opnd_q;
    end
  end

  // Dropping the low 16 bits of a two's complement product rounds toward
  // minus infinity.
  always_comb begin
    acc_d   = (s2_first_q ? '0 : acc_q) +
              {{(ACC_W-RW){s2_prod_q[PW-1]}}, s2_prod_q[PW-1:16]};
    row_sat = sat32(acc_d);
    row_wr  = s2_vld_q && s2_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // Output accumulators and the next-state shadow.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_y) begin
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        y_q[i] <= '0;
      end
    end else if (row_wr && s2_dest_y_q) begin
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        if (RIW'(i) == s2_row_q) begin
          y_q[i] <= row_sat;
        end
      end
    end
    if (cmd_i.shadow_load) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        xs_q[i] <= x_q[i];
      end
    end else if (row_wr && !s2_dest_y_q) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        if (RIW'(i) == s2_row_q) begin
          xs_q[i] <= row_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        x_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < MAX_STATES; i++) begin
        x_q[i] <= xs_q[i];
      end
    end
  end

  // Output register.
  always_comb begin
    y1_sel = '0;
    for (int i = 0; i < MAX_OUTPUTS; i++) begin
      if (i == 1) begin
        y1_sel = y_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      y0_out_q <= y_q[0];
      y1_out_q <= y1_sel;
    end
  end

  assign sts_o.out_free = !m_tvalid_q || m_tready_i;
  assign m_tvalid_o     = m_tvalid_q;
  assign y_first_o      = y0_out_q;
  assign y_second_o     = y1_out_q;

endmodule

// ===== src/discrete_state_space_system.sv =====
// Top level of the discrete state-space system: stream ports, controller and
// datapath. Depends on dss_pkg, dss_ctrl and dss_dp.
//
//   Port group   Role              Payload
//   s_axis_*     input items       opcode, coef_index, coef_value, u_first, u_second
//   m_axis_*     result items      y_first, y_second (output items only)
//   cfg_*        register writes   states_used, inputs_used, outputs_used
//
// A load item writes its coefficient from the LOAD state. An update or output item
// passes SETUP, ISSUE, DRAIN and FINISH, and an output item also waits in FINISH
// for the output register to be free; one shared multiply-accumulate
// pipeline works one product term per cycle. The state resets to zero; the
// coefficient memory is not cleared. A stalled result sits in the output
// register while the next item is taken.
module discrete_state_space_system #(
  parameter int MAX_STATES  = dss_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUTS  = dss_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = dss_pkg::MAX_OUTPUTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode[1:0], coef_index[7:2], coef_value[39:8], u_first[71:40], u_second[103:72]
  input  logic [dss_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // y_first[31:0], y_second[63:32]
  output logic [dss_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int COEF_DEPTH = MAX_STATES * MAX_STATES + MAX_STATES * MAX_INPUTS +
                              MAX_OUTPUTS * MAX_STATES + MAX_OUTPUTS * MAX_INPUTS;
  localparam int AW  = dss_pkg::idx_w(COEF_DEPTH);
  localparam int RIW = dss_pkg::idx_w((MAX_STATES > MAX_OUTPUTS) ? MAX_STATES : MAX_OUTPUTS);
  localparam int OIW = dss_pkg::idx_w((MAX_STATES > MAX_INPUTS) ? MAX_STATES : MAX_INPUTS);

  dss_pkg::cmd_t  cmd;
  dss_pkg::sts_t  sts;
  logic [AW-1:0]  term_addr;
  logic [RIW-1:0] term_row;
  logic [OIW-1:0] term_opnd;
  logic [dss_pkg::DATA_W-1:0] y_first, y_second;

  dss_ctrl #(
    .MAX_STATES  (MAX_STATES),
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .AW          (AW),
    .RIW         (RIW),
    .OIW         (OIW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .term_addr_o (term_addr),
    .term_row_o  (term_row),
    .term_opnd_o (term_opnd)
  );

  dss_dp #(
    .MAX_STATES  (MAX_STATES),
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .COEF_DEPTH  (COEF_DEPTH),
    .AW          (AW),
    .RIW         (RIW),
    .OIW         (OIW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .term_addr_i  (term_addr),
    .term_row_i   (term_row),
    .term_opnd_i  (term_opnd),
    .coef_index_i (s_axis_tdata[7:2]),
    .coef_value_i (s_axis_tdata[39:8]),
    .u_first_i    (s_axis_tdata[71:40]),
    .u_second_i   (s_axis_tdata[103:72]),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .y_first_o    (y_first),
    .y_second_o   (y_second)
  );

  assign m_axis_tdata = {y_second, y_first};

endmodule

// ===== src/dss_checker.sv =====
// Port-level checker for the discrete state-space system, bound to the top.
// Depends on dss_pkg and discrete_state_space_system_macros.svh.
`include "discrete_state_space_system_macros.svh"

module dss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [dss_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dss_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic       in_xfer, out_item, out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_item = in_xfer && (s_axis_tdata[1:0] == dss_pkg::OP_OUTPUT);
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Output items accepted whose result transfer has not happened yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (out_item && !out_xfer) begin
      pend_q <= pend_q + 2'd1;
    end else if (!out_item && out_xfer) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `DSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `DSS_ASSERT(a_no_stray_result, m_axis_tvalid |-> (pend_q != 2'd0),
    "result without an accepted output item")

  `DSS_ASSERT(a_pend_bound, pend_q != 2'd3, "more than two results outstanding")

  `DSS_ASSERT_NEXT(a_busy_after_compute,
    in_xfer && ((s_axis_tdata[1:0] == dss_pkg::OP_OUTPUT) ||
                (s_axis_tdata[1:0] == dss_pkg::OP_UPDATE)),
    !s_axis_tready, "ready stayed high after a compute item")

endmodule

bind discrete_state_space_system dss_checker u_dss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
